### sv/rakh_pkg.sv
// package: shared constants, codes and a helper function for the k-mer hash block
package rakh_pkg;

  // default geometry
  localparam int HASH_BITS_DEF   = 32;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int MAX_KMER_DEF    = 32;
  localparam int CODE_BITS_DEF   = 8;

  // fixed field widths
  localparam int SYM_W      = 8;
  localparam int MAXCODE_W  = 8;
  localparam int KLEN_W     = 6;
  localparam int ENTRIES_W  = 9;
  localparam int RESULT_W   = 32;
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic {
    OP_HASH = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_LIMIT  = 2'd0,
    CFG_KMER_LENGTH = 2'd1,
    CFG_MAP_ENTRIES = 2'd2
  } cfg_idx_t;

  // ceil(log2(mc)), zero for mc <= 1
  function automatic logic [SHIFT_W-1:0] shift_width(input logic [MAXCODE_W-1:0] mc);
    logic [SHIFT_W-1:0] s;
    s = '0;
    for (int i = 0; i < MAXCODE_W; i++) begin
      if ((9'(1) << i) < {1'b0, mc}) begin
        s = s + SHIFT_W'(1);
      end
    end
    return s;
  endfunction

endpackage

### sv/rakh_sym_if.sv
// interface: symbol channel, one symbol or table load per transaction
interface rakh_sym_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [rakh_pkg::SYM_W-1:0]   code_in;
  logic [rakh_pkg::SYM_W-1:0]   table_value;
  logic                         restart;

  modport source (output valid, operation, code_in, table_value, restart, input ready);
  modport sink   (input valid, operation, code_in, table_value, restart, output ready);
endinterface

### sv/rakh_hash_if.sv
// interface: result channel, one k-mer hash per transaction
interface rakh_hash_if;
  logic                            valid;
  logic                            ready;
  logic [rakh_pkg::RESULT_W-1:0]   kmer_hash;
  logic                            bad_symbol;
  logic                            config_usable;

  modport source (output valid, kmer_hash, bad_symbol, config_usable, input ready);
  modport sink   (input valid, kmer_hash, bad_symbol, config_usable, output ready);
endinterface

### sv/reduced_alphabet_kmer_hash_core.sv
// top level: reduced-alphabet k-mer hash with table memory and output register
// pipeline: an accepted symbol's table entry is registered, then a finished k-mer's hash is registered at the outputs
// throughput: one transaction per cycle, unless the output register is held or the error hash is being rebuilt
// after any register write, input acceptance pauses while the error hash
// is rebuilt one symbol per cycle
// reset: synchronous, clears registers, k-mer state and handshakes; table undefined until loaded
module reduced_alphabet_kmer_hash_core #(
  parameter int HASH_BITS   = rakh_pkg::HASH_BITS_DEF,
  parameter int TABLE_DEPTH = rakh_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_KMER    = rakh_pkg::MAX_KMER_DEF,
  parameter int CODE_BITS   = rakh_pkg::CODE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [rakh_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [rakh_pkg::CFG_DATA_W-1:0]     wr_data,
  rakh_sym_if.sink                            sym_in,
  rakh_hash_if.source                         hash_out
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int KW = $clog2(MAX_KMER + 1);

  // configuration registers
  logic [rakh_pkg::MAXCODE_W-1:0] code_limit;
  logic [rakh_pkg::KLEN_W-1:0]    kmer_length;
  logic [rakh_pkg::ENTRIES_W-1:0] map_entries;

  // reduction table, one write or one registered read per cycle
  logic [CODE_BITS-1:0] code_table [TABLE_DEPTH];
  logic [CODE_BITS-1:0] rd_data;

  // stage 1: symbol whose table entry is being read
  logic s1_valid;
  logic s1_restart;
  logic s1_addr_ok;

  // running k-mer state
  logic [HASH_BITS-1:0] partial_hash;
  logic [KW-1:0]        symbol_count;
  logic                 error_seen;

  // error hash builder: max_hash packed over the clamped k-mer length in symbols
  logic                 mh_busy;
  logic [HASH_BITS-1:0] mh_acc;
  logic [KW-1:0]        mh_cnt;

  // output register
  logic                              out_valid;
  logic [rakh_pkg::RESULT_W-1:0]     out_hash;
  logic                              out_bad;
  logic                              out_usable;

  // derived configuration
  logic [rakh_pkg::SHIFT_W-1:0] shift;
  logic [KW-1:0]                k_eff;
  logic [10:0]                  total_bits;
  logic                         usable;

  // handshake and datapath
  logic                 accept;
  logic                 in_range;
  logic                 addr_ok;
  logic [AW-1:0]        addr;
  logic                 out_free;
  logic                 s1_emit;
  logic                 s1_adv;
  logic                 sym_ok;
  logic [HASH_BITS-1:0] base_hash;
  logic [KW-1:0]        base_cnt;
  logic                 base_err;
  logic [HASH_BITS-1:0] hash_next;
  logic [KW-1:0]        count_next;
  logic                 err_next;
  logic [HASH_BITS-1:0] err_hash;

  // shift per symbol, clamped length and the overflow check on shift times length
  always_comb begin
    shift = rakh_pkg::shift_width(code_limit);
    if (32'(kmer_length) > 32'(MAX_KMER)) begin
      k_eff = KW'(MAX_KMER);
    end else begin
      k_eff = KW'(kmer_length);
    end
    total_bits = 11'(shift) * 11'(k_eff);
    if (total_bits > 11'(HASH_BITS)) begin
      usable = 1'b0;
    end else if (total_bits == 11'(HASH_BITS) &&
                 {1'b0, code_limit} == (9'(1) << shift)) begin
      usable = 1'b0;
    end else begin
      usable = 1'b1;
    end
  end

  // configuration writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      code_limit  <= '0;
      kmer_length <= '0;
      map_entries <= '0;
    end else if (wr_en) begin
      case (wr_index)
        rakh_pkg::CFG_CODE_LIMIT:  code_limit  <= wr_data[rakh_pkg::MAXCODE_W-1:0];
        rakh_pkg::CFG_KMER_LENGTH: kmer_length <= wr_data[rakh_pkg::KLEN_W-1:0];
        rakh_pkg::CFG_MAP_ENTRIES: map_entries <= wr_data;
        default: ;
      endcase
    end
  end

  // rebuild the error hash after every register write, one symbol a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mh_busy <= 1'b0;
      mh_acc  <= '0;
      mh_cnt  <= '0;
    end else if (wr_en) begin
      mh_busy <= 1'b1;
      mh_acc  <= '0;
      mh_cnt  <= '0;
    end else if (mh_busy) begin
      if (mh_cnt == k_eff) begin
        mh_busy <= 1'b0;
      end else begin
        mh_acc <= (mh_acc << shift) + HASH_BITS'(code_limit);
        mh_cnt <= mh_cnt + KW'(1);
      end
    end
  end

  assign err_hash = mh_acc + HASH_BITS'(1);

  // input side: table address checks and acceptance
  assign in_range = 9'(sym_in.code_in) < 9'(TABLE_DEPTH);
  assign addr_ok  = in_range && (9'(sym_in.code_in) < map_entries);
  assign addr     = sym_in.code_in[AW-1:0];

  assign out_free = !out_valid || hash_out.ready;
  assign s1_adv   = s1_valid && (!s1_emit || out_free);
  assign sym_in.ready = !mh_busy && (!s1_valid || s1_adv);
  assign accept   = sym_in.valid && sym_in.ready;

  // loads write at acceptance, so a symbol taken in the next cycle already sees the entry
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      if (sym_in.operation == rakh_pkg::OP_LOAD) begin
        code_table[addr] <= sym_in.table_value[CODE_BITS-1:0];
      end else begin
        rd_data <= code_table[addr];
      end
    end
  end

  // stage 1 control; loads leave nothing behind
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (sym_in.operation == rakh_pkg::OP_HASH);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_restart <= sym_in.restart;
      s1_addr_ok <= addr_ok;
    end
  end

  // read-modify-write of the k-mer state with the table entry
  always_comb begin
    base_hash = s1_restart ? '0 : partial_hash;
    base_cnt  = s1_restart ? '0 : symbol_count;
    base_err  = s1_restart ? 1'b0 : error_seen;
    sym_ok    = s1_addr_ok && (8'(rd_data) <= code_limit);
    if (k_eff == '0) begin
      // zero length: nothing accumulates, every symbol yields a zero hash
      hash_next  = base_hash;
      count_next = base_cnt;
      err_next   = base_err;
      s1_emit    = s1_valid;
    end else begin
      hash_next  = sym_ok ? (base_hash << shift) + HASH_BITS'(rd_data) : base_hash;
      count_next = base_cnt + KW'(1);
      err_next   = base_err || !sym_ok;
      s1_emit    = s1_valid && (count_next >= k_eff);
    end
  end

  // zero length keeps the k-mer state, only a restart clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_hash <= '0;
      symbol_count <= '0;
      error_seen   <= 1'b0;
    end else if (s1_adv) begin
      if (s1_emit && (k_eff != '0)) begin
        partial_hash <= '0;
        symbol_count <= '0;
        error_seen   <= 1'b0;
      end else begin
        partial_hash <= hash_next;
        symbol_count <= count_next;
        error_seen   <= err_next;
      end
    end
  end

  // output register, refilled in the cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid <= 1'b1;
    end else if (hash_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_usable <= usable;
      if (k_eff == '0) begin
        out_hash <= '0;
        out_bad  <= 1'b0;
      end else if (err_next) begin
        out_hash <= rakh_pkg::RESULT_W'(err_hash);
        out_bad  <= 1'b1;
      end else begin
        out_hash <= rakh_pkg::RESULT_W'(hash_next);
        out_bad  <= 1'b0;
      end
    end
  end

  assign hash_out.valid         = out_valid;
  assign hash_out.kmer_hash     = out_hash;
  assign hash_out.bad_symbol    = out_bad;
  assign hash_out.config_usable = out_usable;

`ifndef NO_ASSERTIONS
  // no symbol enters while the error hash is being rebuilt
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    sym_in.valid && sym_in.ready |-> !mh_busy)
    else $error("symbol accepted during error hash rebuild");

  // a stalled stage 1 keeps its symbol
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_addr_ok) && $stable(s1_restart))
    else $error("stage 1 lost its symbol while stalled");

  // a pending result is never overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hash_out.ready |-> !(s1_adv && s1_emit))
    else $error("result overwritten before it was taken");
`endif

endmodule
